/* design/pdp_pkg.sv */
`default_nettype none

package pdp_pkg;

    localparam int VW                = 48;
    localparam int FRAC_BITS         = 32;
    localparam int COEF_BITS         = 28;
    localparam int CW                = 32;
    localparam int FW                = 47;
    localparam int HALF              = 24;
    localparam int REFINE_STEPS_DEF  = 8;
    localparam int MUL_LAT           = 4;
    localparam int STEP_LAT          = 19;
    localparam int QB                = VW + 1;

    typedef logic signed [VW-1:0] t_val;

    localparam t_val VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam t_val VMIN = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_K1,
        REG_K2,
        REG_P1,
        REG_P2
    } t_reg_idx;

    typedef struct packed {
        logic req_type;
        t_val in_x;
        t_val in_y;
        t_val in_z;
    } t_req;

    typedef struct packed {
        t_val out_a;
        t_val out_b;
        logic range_error;
    } t_res;

    typedef struct packed {
        logic [FW-1:0] focal_x;
        logic [FW-1:0] focal_y;
        t_val          center_x;
        t_val          center_y;
        logic [CW-1:0] radial_k1;
        logic [CW-1:0] radial_k2;
        logic [CW-1:0] tangential_p1;
        logic [CW-1:0] tangential_p2;
    } t_cfg;

    // one transaction in flight through the distortion steps
    typedef struct packed {
        logic valid;
        logic back;
        logic zd;
        logic flag;
        t_val mx;
        t_val my;
        t_val ex;
        t_val ey;
    } t_ctx;

    typedef struct packed {
        logic fl;
        t_val v;
    } t_sat;

    typedef struct packed {
        logic          neg;
        logic [VW-1:0] ma;
        logic [VW-1:0] mb;
    } t_mabs;

    typedef struct packed {
        logic          neg;
        logic [VW-1:0] p00;
        logic [VW-1:0] p01;
        logic [VW-1:0] p10;
        logic [VW-1:0] p11;
    } t_mpart;

    typedef struct packed {
        logic          neg;
        logic          huge;
        logic [VW-1:0] mag;
    } t_mrnd;

    function automatic t_val coef(input logic [CW-1:0] c);
        coef = {{(VW-CW){c[CW-1]}}, c};
    endfunction

    function automatic t_sat sat_add(input t_val a, input t_val b);
        logic [VW:0] s;
        t_sat        r;
        s = {a[VW-1], a} + {b[VW-1], b};
        r.fl = s[VW] ^ s[VW-1];
        r.v  = r.fl ? (s[VW] ? VMIN : VMAX) : s[VW-1:0];
        return r;
    endfunction

    function automatic t_sat sat_sub(input t_val a, input t_val b);
        logic [VW:0] s;
        t_sat        r;
        s = {a[VW-1], a} - {b[VW-1], b};
        r.fl = s[VW] ^ s[VW-1];
        r.v  = r.fl ? (s[VW] ? VMIN : VMAX) : s[VW-1:0];
        return r;
    endfunction

    // sign and magnitude back to a saturated value
    function automatic t_sat pack(input logic neg, input logic [VW-1:0] mag,
                                  input logic huge);
        t_sat r;
        r.fl = 1'b0;
        if (neg) begin
            if (huge || (mag > {1'b1, {(VW-1){1'b0}}})) begin
                r.fl = 1'b1;
                r.v  = VMIN;
            end else begin
                r.v = {VW{1'b0}} - mag;
            end
        end else begin
            if (huge || mag[VW-1]) begin
                r.fl = 1'b1;
                r.v  = VMAX;
            end else begin
                r.v = mag;
            end
        end
        return r;
    endfunction

    function automatic t_mabs mul_a(input t_val a, input t_val b);
        t_mabs r;
        r.neg = a[VW-1] ^ b[VW-1];
        r.ma  = a[VW-1] ? ({VW{1'b0}} - a) : a;
        r.mb  = b[VW-1] ? ({VW{1'b0}} - b) : b;
        return r;
    endfunction

    function automatic t_mpart mul_b(input t_mabs m);
        t_mpart r;
        r.neg = m.neg;
        r.p00 = m.ma[HALF-1:0]  * m.mb[HALF-1:0];
        r.p01 = m.ma[HALF-1:0]  * m.mb[VW-1:HALF];
        r.p10 = m.ma[VW-1:HALF] * m.mb[HALF-1:0];
        r.p11 = m.ma[VW-1:HALF] * m.mb[VW-1:HALF];
        return r;
    endfunction

    // partial product sum with round-half-up on the magnitude, then shift
    function automatic t_mrnd mul_c(input t_mpart p, input int unsigned s);
        logic [2*VW:0] sum;
        logic [2*VW:0] sh;
        t_mrnd         r;
        sum = {{(VW+1){1'b0}}, p.p00}
            + ({{(VW+1){1'b0}}, p.p01} << HALF)
            + ({{(VW+1){1'b0}}, p.p10} << HALF)
            + ({{(VW+1){1'b0}}, p.p11} << (2*HALF))
            + ({{(2*VW){1'b0}}, 1'b1} << (s - 1));
        sh     = sum >> s;
        r.neg  = p.neg;
        r.mag  = sh[VW-1:0];
        r.huge = |sh[2*VW:VW];
        return r;
    endfunction

    function automatic t_sat mul_d(input t_mrnd m);
        mul_d = pack(m.neg, m.mag, m.huge);
    endfunction

endpackage

`default_nettype wire

/* design/pdp_step.sv */
`default_nettype none

module pdp_step #(
    parameter bit FIRST = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pdp_pkg::t_cfg i_cfg,
    input  pdp_pkg::t_ctx i_ctx,
    output pdp_pkg::t_ctx o_ctx
);
    import pdp_pkg::*;

    localparam int NL = 12;

    typedef struct packed {
        t_val t1;
        t_val t2;
        t_val px;
        t_val py;
        t_val k1r2;
    } t_terms;

    t_val   m_a [NL];
    t_val   m_b [NL];
    t_mabs  r_ma [NL];
    t_mpart r_mp [NL];
    t_mrnd  r_mr [NL];
    t_val   r_mv [NL];
    logic   r_mf [NL];

    t_ctx   r_c [1:18];
    t_ctx   n_c [2:18];
    t_terms r_dl [10:18];
    t_val   r_r2, r_sx, r_sy, r_xy, r_rad;
    t_ctx   r_o;
    t_ctx   n_o;

    t_sat   s_r2, s_xx, s_yy, s_sx, s_sy, s_rad;
    t_sat   s_tx, s_ty, s_ax, s_ay, s_dx, s_dy, s_ex, s_ey;
    logic   fl_fin;

    function automatic int unsigned lane_shift(input int i);
        lane_shift = (i >= 4 && i <= 9) ? COEF_BITS : FRAC_BITS;
    endfunction

    // lanes: x2 y2 xy | r4 t1 t2 px py k1r2 | k2r4 | x*rad y*rad
    always_comb begin
        m_a[0]  = i_ctx.ex;               m_b[0]  = i_ctx.ex;
        m_a[1]  = i_ctx.ey;               m_b[1]  = i_ctx.ey;
        m_a[2]  = i_ctx.ex;               m_b[2]  = i_ctx.ey;
        m_a[3]  = r_r2;                   m_b[3]  = r_r2;
        m_a[4]  = coef(i_cfg.tangential_p1); m_b[4] = r_xy;
        m_a[5]  = coef(i_cfg.tangential_p2); m_b[5] = r_xy;
        m_a[6]  = coef(i_cfg.tangential_p2); m_b[6] = r_sx;
        m_a[7]  = coef(i_cfg.tangential_p1); m_b[7] = r_sy;
        m_a[8]  = coef(i_cfg.radial_k1);  m_b[8]  = r_r2;
        m_a[9]  = coef(i_cfg.radial_k2);  m_b[9]  = r_mv[3];
        m_a[10] = r_c[14].ex;             m_b[10] = r_rad;
        m_a[11] = r_c[14].ey;             m_b[11] = r_rad;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NL; i++) begin
            r_ma[i] <= mul_a(m_a[i], m_b[i]);
            r_mp[i] <= mul_b(r_ma[i]);
            r_mr[i] <= mul_c(r_mp[i], lane_shift(i));
            {r_mf[i], r_mv[i]} <= mul_d(r_mr[i]);
        end
    end

    always_comb begin
        s_r2  = sat_add(r_mv[0], r_mv[1]);
        s_xx  = sat_add(r_mv[0], r_mv[0]);
        s_yy  = sat_add(r_mv[1], r_mv[1]);
        s_sx  = sat_add(s_r2.v, s_xx.v);
        s_sy  = sat_add(s_r2.v, s_yy.v);
        s_rad = sat_add(r_dl[13].k1r2, r_mv[9]);

        s_tx  = sat_add(r_dl[18].t1, r_dl[18].t1);
        s_ty  = sat_add(r_dl[18].t2, r_dl[18].t2);
        s_ax  = sat_add(r_mv[10], s_tx.v);
        s_ay  = sat_add(r_mv[11], s_ty.v);
        s_dx  = sat_add(s_ax.v, r_dl[18].px);
        s_dy  = sat_add(s_ay.v, r_dl[18].py);
        if (r_c[18].back) begin
            s_ex = sat_sub(r_c[18].mx, s_dx.v);
            s_ey = sat_sub(r_c[18].my, s_dy.v);
        end else if (FIRST) begin
            s_ex = sat_add(r_c[18].mx, s_dx.v);
            s_ey = sat_add(r_c[18].my, s_dy.v);
        end else begin
            s_ex = '{fl: 1'b0, v: r_c[18].ex};
            s_ey = '{fl: 1'b0, v: r_c[18].ey};
        end
        fl_fin = r_mf[10] | r_mf[11] | s_tx.fl | s_ty.fl | s_ax.fl | s_ay.fl
               | s_dx.fl | s_dy.fl | s_ex.fl | s_ey.fl;

        n_o      = r_c[18];
        n_o.ex   = s_ex.v;
        n_o.ey   = s_ey.v;
        n_o.flag = r_c[18].flag | ((FIRST || r_c[18].back) & fl_fin);

        for (int k = 2; k <= 18; k++) begin
            n_c[k] = r_c[k-1];
        end
        // project items only pick up flags in the first step
        n_c[5].flag  = r_c[4].flag | ((FIRST || r_c[4].back)
                     & (r_mf[0] | r_mf[1] | r_mf[2] | s_r2.fl | s_xx.fl
                        | s_yy.fl | s_sx.fl | s_sy.fl));
        n_c[10].flag = r_c[9].flag | ((FIRST || r_c[9].back)
                     & (r_mf[3] | r_mf[4] | r_mf[5] | r_mf[6] | r_mf[7] | r_mf[8]));
        n_c[14].flag = r_c[13].flag | ((FIRST || r_c[13].back) & (r_mf[9] | s_rad.fl));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 18; k++) begin
                r_c[k].valid <= 1'b0;
            end
            r_o.valid <= 1'b0;
        end else begin
            r_c[1] <= i_ctx;
            for (int k = 2; k <= 18; k++) begin
                r_c[k] <= n_c[k];
            end
            r_o <= n_o;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2  <= s_r2.v;
        r_sx  <= s_sx.v;
        r_sy  <= s_sy.v;
        r_xy  <= r_mv[2];
        r_rad <= s_rad.v;
        r_dl[10] <= '{t1: r_mv[4], t2: r_mv[5], px: r_mv[6], py: r_mv[7], k1r2: r_mv[8]};
        for (int k = 11; k <= 18; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
    end

    assign o_ctx = r_o;

endmodule

`default_nettype wire

/* design/pinhole_distortion_projector.sv */
`default_nettype none

// Pinhole projection and back-projection with two radial and two tangential
// distortion terms, in saturating fixed point. One transaction is taken in
// every clock cycle (busy is high only during reset and the cycle after it)
// and its result appears on o_done/o_res after the request register, the
// setup register, the bit-per-stage divider, the unrolled distortion steps,
// the focal multiplier and the output register; results come out in order and
// are shown for exactly one cycle, so the receiver must take them when they
// appear. Most of the pipeline depth lies in the divider and in the distortion
// steps, each step built around its chain of four dependent multiplies.
// Configuration writes take effect at once and must be made while
// no transaction is in flight.
module pinhole_distortion_projector #(
    parameter int REFINE_STEPS = pdp_pkg::REFINE_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pdp_pkg::t_req i_req,
    output logic          o_done,
    output pdp_pkg::t_res o_res,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [pdp_pkg::VW-1:0] i_cfg_data
);
    import pdp_pkg::*;

    localparam int NS  = REFINE_STEPS + 1;
    localparam int LAT = QB + 9 + NS * STEP_LAT;

    typedef struct packed {
        logic valid;
        logic back;
        logic zd;
        logic flag;
    } t_side;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [VW-1:0] r;
        logic [VW-1:0] d;
        logic [QB-1:0] nl;
        logic [QB-1:0] q;
    } t_dstg;

    logic  r_busy;
    t_cfg  r_cfg;
    logic  r_s1_v;
    t_req  r_s1_req;
    t_side r_s2;
    t_side n_s2;
    t_val  r_s2_n [2];
    t_val  r_s2_d [2];
    t_side r_sd [0:QB];
    t_dstg r_dv [2][0:QB];
    t_ctx  r_c0;
    t_ctx  n_c0;
    t_ctx  w_c [0:NS];
    t_ctx  r_fc [1:MUL_LAT];
    t_mabs  r_fma [2];
    t_mpart r_fmp [2];
    t_mrnd  r_fmr [2];
    t_val   r_fv [2];
    logic   r_ff [2];
    logic  r_done;
    t_res  r_res;

    t_sat  s_nx, s_ny, s_qx, s_qy, s_pa, s_pb;
    t_dstg s_d0 [2];
    logic  accept;

    function automatic t_dstg div_setup(input t_val a, input t_val b);
        logic [VW+FRAC_BITS:0]   nfull;
        logic [VW-1:0]           ma;
        logic [VW-1:0]           hi;
        t_dstg                   r;
        ma      = a[VW-1] ? ({VW{1'b0}} - a) : a;
        r.d     = b[VW-1] ? ({VW{1'b0}} - b) : b;
        r.neg   = a[VW-1] ^ b[VW-1];
        nfull   = {ma, {(FRAC_BITS+1){1'b0}}};
        hi      = {{(VW-FRAC_BITS){1'b0}}, nfull[VW+FRAC_BITS:QB]};
        r.ovf   = (hi >= r.d);
        r.r     = hi;
        r.nl    = nfull[QB-1:0];
        r.q     = '0;
        return r;
    endfunction

    function automatic t_dstg div_step(input t_dstg s);
        logic [VW:0] rr;
        t_dstg       r;
        r  = s;
        rr = {s.r, s.nl[QB-1]};
        if (rr >= {1'b0, s.d}) begin
            rr  = rr - {1'b0, s.d};
            r.q = {s.q[QB-2:0], 1'b1};
        end else begin
            r.q = {s.q[QB-2:0], 1'b0};
        end
        r.r  = rr[VW-1:0];
        r.nl = {s.nl[QB-2:0], 1'b0};
        return r;
    endfunction

    function automatic t_sat div_fin(input t_dstg s);
        logic [QB:0] qr;
        qr = {1'b0, s.q} + {{QB{1'b0}}, 1'b1};
        div_fin = pack(s.neg, qr[VW:1], s.ovf | qr[QB]);
    endfunction

    assign accept = start & ~busy;
    assign busy   = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cfg  <= '{focal_x: 47'd2147483648000, focal_y: 47'd2147483648000,
                        center_x: 48'sd1374389534720, center_y: 48'sd1030792151040,
                        radial_k1: '0, radial_k2: '0,
                        tangential_p1: '0, tangential_p2: '0};
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_FOCAL_X:  r_cfg.focal_x       <= i_cfg_data[FW-1:0];
                    REG_FOCAL_Y:  r_cfg.focal_y       <= i_cfg_data[FW-1:0];
                    REG_CENTER_X: r_cfg.center_x      <= i_cfg_data;
                    REG_CENTER_Y: r_cfg.center_y      <= i_cfg_data;
                    REG_K1:       r_cfg.radial_k1     <= i_cfg_data[CW-1:0];
                    REG_K2:       r_cfg.radial_k2     <= i_cfg_data[CW-1:0];
                    REG_P1:       r_cfg.tangential_p1 <= i_cfg_data[CW-1:0];
                    REG_P2:       r_cfg.tangential_p2 <= i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // numerator and denominator per request type
    always_comb begin
        s_nx = sat_sub(r_s1_req.in_x, r_cfg.center_x);
        s_ny = sat_sub(r_s1_req.in_y, r_cfg.center_y);
        s_d0[0] = div_setup(r_s2_n[0], r_s2_d[0]);
        s_d0[1] = div_setup(r_s2_n[1], r_s2_d[1]);
        s_qx = div_fin(r_dv[0][QB]);
        s_qy = div_fin(r_dv[1][QB]);
        s_pa = sat_add(r_fv[0], r_cfg.center_x);
        s_pb = sat_add(r_fv[1], r_cfg.center_y);

        n_s2.valid = r_s1_v;
        n_s2.back  = r_s1_req.req_type;
        if (r_s1_req.req_type) begin
            n_s2.zd   = 1'b0;
            n_s2.flag = s_nx.fl | s_ny.fl;
        end else begin
            n_s2.zd   = (r_s1_req.in_z == '0);
            n_s2.flag = 1'b0;
        end

        n_c0.valid = r_sd[QB].valid;
        n_c0.back  = r_sd[QB].back;
        n_c0.zd    = r_sd[QB].zd;
        n_c0.flag  = r_sd[QB].flag | s_qx.fl | s_qy.fl;
        n_c0.mx    = s_qx.v;
        n_c0.my    = s_qy.v;
        n_c0.ex    = s_qx.v;
        n_c0.ey    = s_qy.v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2.valid <= 1'b0;
            for (int j = 0; j <= QB; j++) begin
                r_sd[j].valid <= 1'b0;
            end
            r_c0.valid <= 1'b0;
            for (int k = 1; k <= MUL_LAT; k++) begin
                r_fc[k].valid <= 1'b0;
            end
            r_done <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2   <= n_s2;
            r_sd[0] <= r_s2;
            for (int j = 1; j <= QB; j++) begin
                r_sd[j] <= r_sd[j-1];
            end
            r_c0 <= n_c0;
            r_fc[1] <= w_c[NS];
            for (int k = 2; k <= MUL_LAT; k++) begin
                r_fc[k] <= r_fc[k-1];
            end
            r_done <= r_fc[MUL_LAT].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_req <= i_req;
        if (r_s1_req.req_type) begin
            r_s2_n[0] <= s_nx.v;
            r_s2_n[1] <= s_ny.v;
            r_s2_d[0] <= {1'b0, r_cfg.focal_x};
            r_s2_d[1] <= {1'b0, r_cfg.focal_y};
        end else begin
            r_s2_n[0] <= r_s1_req.in_x;
            r_s2_n[1] <= r_s1_req.in_y;
            r_s2_d[0] <= r_s1_req.in_z;
            r_s2_d[1] <= r_s1_req.in_z;
        end
        for (int l = 0; l < 2; l++) begin
            r_dv[l][0] <= s_d0[l];
            for (int j = 1; j <= QB; j++) begin
                r_dv[l][j] <= div_step(r_dv[l][j-1]);
            end
        end

        // focal scaling for project results
        r_fma[0] <= mul_a({1'b0, r_cfg.focal_x}, w_c[NS].ex);
        r_fma[1] <= mul_a({1'b0, r_cfg.focal_y}, w_c[NS].ey);
        for (int l = 0; l < 2; l++) begin
            r_fmp[l] <= mul_b(r_fma[l]);
            r_fmr[l] <= mul_c(r_fmp[l], FRAC_BITS);
            {r_ff[l], r_fv[l]} <= mul_d(r_fmr[l]);
        end

        if (r_fc[MUL_LAT].back) begin
            r_res <= '{out_a: r_fc[MUL_LAT].ex, out_b: r_fc[MUL_LAT].ey,
                       range_error: r_fc[MUL_LAT].flag};
        end else if (r_fc[MUL_LAT].zd) begin
            r_res <= '{out_a: r_fc[MUL_LAT].mx[VW-1] ? VMIN : VMAX,
                       out_b: r_fc[MUL_LAT].my[VW-1] ? VMIN : VMAX,
                       range_error: 1'b1};
        end else begin
            r_res <= '{out_a: s_pa.v, out_b: s_pb.v,
                       range_error: r_fc[MUL_LAT].flag | r_ff[0] | r_ff[1]
                                    | s_pa.fl | s_pb.fl};
        end
    end

    assign w_c[0] = r_c0;

    for (genvar s = 0; s < NS; s++) begin : g_step
        pdp_step #(
            .FIRST (s == 0)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_ctx   (w_c[s]),
            .o_ctx   (w_c[s+1])
        );
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("accepted transaction did not complete on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LAT))
        else $error("result without a matching transaction");

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fc[MUL_LAT].valid && !r_fc[MUL_LAT].back && r_fc[MUL_LAT].zd)
        |=> (o_done && o_res.range_error))
        else $error("zero depth not flagged");

endmodule

`default_nettype wire
